// ===== sv/dawu_pkg.sv =====
package dawu_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CODE_W = 12;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned AUX_W = 8;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned PEAK_W = 12;
  localparam int unsigned PAD_SHIFT = 4;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned OUT_DATA_W = 2 * SAMPLE_W + AUX_W + 2 * COUNT_W + 2 * PEAK_W;

  localparam logic [CODE_W:0] MID_CODE = (CODE_W + 1)'(2047);
  localparam int unsigned B_LSB = 20;
  localparam int unsigned AUX_LSB = 12;
  localparam int unsigned CLIP_A_BIT = 12;
  localparam int unsigned CLIP_B_BIT = 13;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CHAN_A_ENABLE = 3'd0,
    CFG_CHAN_B_ENABLE = 3'd1,
    CFG_PAD_ENABLE    = 3'd2,
    CFG_PEAK_ENABLE   = 3'd3,
    CFG_SINGLE_MODE   = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic chan_a_enable;
    logic chan_b_enable;
    logic pad_enable;
    logic peak_enable;
    logic single_mode;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] clip_count_a;
    logic [COUNT_W-1:0] clip_count_b;
    logic [PEAK_W-1:0]  peak_level_a;
    logic [PEAK_W-1:0]  peak_level_b;
  } track_t;

  // packed MSB first, so sample_a lands in the lowest bits
  typedef struct packed {
    logic [PEAK_W-1:0]          peak_b;
    logic [PEAK_W-1:0]          peak_a;
    logic [COUNT_W-1:0]         clip_total_b;
    logic [COUNT_W-1:0]         clip_total_a;
    logic [AUX_W-1:0]           aux_bits;
    logic signed [SAMPLE_W-1:0] sample_b;
    logic signed [SAMPLE_W-1:0] sample_a;
  } result_t;

endpackage

// ===== sv/dawu_unpack.sv =====
module dawu_unpack (
  input  logic [dawu_pkg::WORD_W-1:0] raw_word,
  input  logic                        block_start,
  input  dawu_pkg::cfg_t              cfg,
  input  dawu_pkg::track_t            track,
  output dawu_pkg::track_t            track_next,
  output dawu_pkg::result_t           result
);
  import dawu_pkg::*;

  logic [WORD_W-1:0]        w;
  logic [CODE_W-1:0]        code_a;
  logic [CODE_W-1:0]        code_b;
  logic signed [CODE_W-1:0] va;
  logic signed [CODE_W-1:0] vb;
  logic [PEAK_W-1:0]        mag_a;
  logic [PEAK_W-1:0]        mag_b;
  logic [PEAK_W-1:0]        base_a;
  logic [PEAK_W-1:0]        base_b;
  logic                     en_a;
  logic                     en_b;
  logic                     peaks;
  logic                     trk_a;
  logic                     trk_b;
  logic [CODE_W:0]          diff_a;
  logic [CODE_W:0]          diff_b;

  assign w      = cfg.single_mode ? {{(WORD_W-16){1'b0}}, raw_word[15:0]} : raw_word;
  assign code_a = w[CODE_W-1:0];
  assign code_b = w[B_LSB +: CODE_W];

  assign diff_a = MID_CODE - {1'b0, code_a};
  assign diff_b = MID_CODE - {1'b0, code_b};
  assign va     = signed'(diff_a[CODE_W-1:0]);
  assign vb     = signed'(diff_b[CODE_W-1:0]);

  assign mag_a  = va[CODE_W-1] ? PEAK_W'(-va) : PEAK_W'(va);
  assign mag_b  = vb[CODE_W-1] ? PEAK_W'(-vb) : PEAK_W'(vb);

  assign en_a   = cfg.chan_a_enable;
  assign en_b   = cfg.chan_b_enable && !cfg.single_mode;
  assign peaks  = cfg.peak_enable && !cfg.single_mode;
  assign trk_a  = peaks && (en_a || !en_b);
  assign trk_b  = peaks && (en_b || !en_a);

  assign base_a = block_start ? '0 : track.peak_level_a;
  assign base_b = block_start ? '0 : track.peak_level_b;

  always_comb begin
    track_next = track;
    if (en_a && w[CLIP_A_BIT] && (track.clip_count_a != '1)) begin
      track_next.clip_count_a = track.clip_count_a + COUNT_W'(1);
    end
    if (en_b && w[CLIP_B_BIT] && (track.clip_count_b != '1)) begin
      track_next.clip_count_b = track.clip_count_b + COUNT_W'(1);
    end
    track_next.peak_level_a = (trk_a && (mag_a > base_a)) ? mag_a : base_a;
    track_next.peak_level_b = (trk_b && (mag_b > base_b)) ? mag_b : base_b;
  end

  always_comb begin
    result = '0;
    if (en_a) begin
      result.sample_a = cfg.pad_enable ? {va, {PAD_SHIFT{1'b0}}} : SAMPLE_W'(va);
    end
    if (en_b) begin
      result.sample_b = cfg.pad_enable ? {vb, {PAD_SHIFT{1'b0}}} : SAMPLE_W'(vb);
    end
    result.aux_bits     = cfg.single_mode ? {4'b0000, w[AUX_LSB +: 4]} : w[AUX_LSB +: AUX_W];
    result.clip_total_a = track_next.clip_count_a;
    result.clip_total_b = track_next.clip_count_b;
    result.peak_a       = trk_a ? track_next.peak_level_a : '0;
    result.peak_b       = trk_b ? track_next.peak_level_b : '0;
  end

endmodule

// ===== sv/dual_adc_word_unpack_clip_peak.sv =====
// Dual 12-bit ADC capture word unpacker with clip counters and block peaks.
//
// Input stream: s_tdata carries one 32-bit capture word (channel A in bits
// 11:0, aux/clip flags in 19:12, channel B in 31:20); s_tuser marks the first
// word of a block. Output stream: m_tdata carries one 128-bit result per
// input word. Configuration: cfg_valid/cfg_ready with cfg_index selecting one
// of five one-bit registers (cfg_data[0]); cfg_ready is always high, and
// registers are meant to be written only while the stream is idle.
//
// Each word passes through one input register, then the unpack/count/peak
// logic into the output register.
// Throughput is one word per cycle while m_tready is high; the clip
// counters and peak levels are updated as a word moves into the output
// register, so each word sees the state left by the one before it.
//
// Reset clears both stages, the counters and peaks, and loads the register
// defaults (both channels on, padding, peaks and single mode off). When the
// receiver stalls, the output holds and the input register fills, after
// which s_tready drops until m_tready returns.
module dual_adc_word_unpack_clip_peak (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [dawu_pkg::WORD_W-1:0]         s_tdata,   // raw_word
  input  logic                                s_tuser,   // block_start
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // sample_a, sample_b, aux_bits, clip_total_a, clip_total_b, peak_a, peak_b
  output logic [dawu_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dawu_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic                                cfg_data
);
  import dawu_pkg::*;

  cfg_t              cfg;
  track_t            track;
  track_t            track_next;
  result_t           result;
  logic              in_valid;
  logic [WORD_W-1:0] in_word;
  logic              in_start;
  logic              advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{chan_a_enable: 1'b1, chan_b_enable: 1'b1, pad_enable: 1'b0,
               peak_enable: 1'b0, single_mode: 1'b0};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_CHAN_A_ENABLE: cfg.chan_a_enable <= cfg_data;
        CFG_CHAN_B_ENABLE: cfg.chan_b_enable <= cfg_data;
        CFG_PAD_ENABLE:    cfg.pad_enable    <= cfg_data;
        CFG_PEAK_ENABLE:   cfg.peak_enable   <= cfg_data;
        CFG_SINGLE_MODE:   cfg.single_mode   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_word  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  dawu_unpack u_unpack (
    .raw_word    (in_word),
    .block_start (in_start),
    .cfg         (cfg),
    .track       (track),
    .track_next  (track_next),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      track    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        track    <= track_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= result;
    end
  end

endmodule

// ===== sv/dawu_checker.sv =====
module dawu_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [dawu_pkg::OUT_DATA_W-1:0] m_tdata
);
  import dawu_pkg::*;

  result_t            res;
  logic               seen;
  logic [COUNT_W-1:0] last_a;
  logic [COUNT_W-1:0] last_b;

  assign res = m_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      last_a <= res.clip_total_a;
      last_b <= res.clip_total_b;
    end
  end

  a_reset_empty: assert property (@(posedge clk) $past(rst) && !rst |-> !m_tvalid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output changed");

  a_peak_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.peak_a <= PEAK_W'(2048)) && (res.peak_b <= PEAK_W'(2048)))
    else $error("peak level out of range");

  a_clip_monotonic: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && seen |->
      (res.clip_total_a >= last_a) && (res.clip_total_b >= last_b))
    else $error("clip count decreased");

endmodule

bind dual_adc_word_unpack_clip_peak dawu_checker u_dawu_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
